// ===== design/lzo_pkg.sv =====
// Shared types and constants of the LZO1X stream decompressor.
// No dependencies; used by the front, queue, back and top level.
`timescale 1ns / 1ps
package lzo_pkg;

   localparam int LEN_W    = 12;
   localparam int DIST_W   = 16;
   localparam int CNT_W    = 25;
   localparam int STAT_W   = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CNT_W-1:0] CAP_RESET = 25'd16777216;
   localparam logic [LEN_W-1:0] LEN_SAT   = 12'd4095;
   localparam logic [DIST_W-1:0] END_DIST = 16'h4000;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD_INSN = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_DIST = 3'd2;
   localparam logic [STAT_W-1:0] ST_LONG     = 3'd3;
   localparam logic [STAT_W-1:0] ST_DONE     = 3'd4;

   // One command per accepted compressed byte.
   typedef struct packed {
      logic              lit;
      logic [7:0]        data;
      logic [LEN_W-1:0]  len;
      logic [DIST_W-1:0] distance;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  total;
   } cmd_type;

endpackage

// ===== design/lzo_front.sv =====
// Parser of the decompressor: accepts compressed bytes, decodes instructions
// and issues one copy command per byte. Depends on lzo_pkg.
`timescale 1ns / 1ps
module lzo_front
   import lzo_pkg::*;
#(
   parameter int MAX_MATCH = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   output logic             in_ready,
   input  logic             q_full,
   output logic             q_push,
   output cmd_type          q_cmd
);

   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_INSTR   = 3'd1;
   localparam logic [2:0] PH_EXT     = 3'd2;
   localparam logic [2:0] PH_M2      = 3'd3;
   localparam logic [2:0] PH_FOLLOW1 = 3'd4;
   localparam logic [2:0] PH_FOLLOW2 = 3'd5;
   localparam logic [2:0] PH_LITS    = 3'd6;
   localparam logic [2:0] PH_DONE    = 3'd7;

   logic [2:0]        phase_ff, phase_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [DIST_W-1:0] mdist_ff, mdist_in;
   logic [2:0]        lstate_ff, lstate_in;
   logic [LEN_W-1:0]  lleft_ff, lleft_in;
   logic [7:0]        lowb_ff, lowb_in;
   logic [CNT_W-1:0]  wc_ff, wc_in;
   logic [CNT_W-1:0]  cap_ff;

   logic [CNT_W-1:0]  room;
   logic              take;
   logic              instr;
   logic              m_go, m_m4;
   logic [LEN_W-1:0]  m_len, m_clamp;
   logic [DIST_W-1:0] m_dist;
   logic [1:0]        m_st;
   logic [4:0]        low;
   logic [DIST_W-1:0] base;
   logic              low_go;
   logic [LEN_W:0]    ext_sum;
   logic [4:0]        mask;
   logic              ext_lit;
   logic [15:0]       follow;

   assign in_ready = !q_full;
   assign take     = in_valid && !q_full;
   assign q_push   = take;
   assign room     = (cap_ff > wc_ff) ? cap_ff - wc_ff : '0;

   always_comb begin
      phase_in  = phase_ff;
      plen_in   = plen_ff;
      mdist_in  = mdist_ff;
      lstate_in = lstate_ff;
      lleft_in  = lleft_ff;
      lowb_in   = lowb_ff;
      wc_in     = wc_ff;
      q_cmd     = '0;
      instr     = 1'b0;
      m_go      = 1'b0;
      m_m4      = 1'b0;
      m_len     = plen_ff;
      m_dist    = '0;
      m_st      = '0;
      m_clamp   = '0;
      low       = '0;
      base      = '0;
      low_go    = 1'b0;
      ext_sum   = '0;
      ext_lit   = (mdist_ff == '0);
      mask      = ext_lit ? 5'd15 : ((mdist_ff >= END_DIST) ? 5'd7 : 5'd31);
      follow    = {in_byte, lowb_ff};

      unique case (phase_ff)
         PH_FIRST: begin
            if (in_byte > 8'd17) begin
               lleft_in  = {4'd0, in_byte - 8'd17};
               lstate_in = 3'd4;
               phase_in  = PH_LITS;
            end else begin
               instr = 1'b1;
            end
         end
         PH_INSTR: instr = 1'b1;
         PH_EXT: begin
            if (in_byte == 8'd0) begin
               ext_sum = {1'b0, plen_ff} + (LEN_W+1)'(255);
               plen_in = (ext_sum > {1'b0, LEN_SAT}) ? LEN_SAT : ext_sum[LEN_W-1:0];
            end else begin
               ext_sum = {1'b0, plen_ff} + (LEN_W+1)'(in_byte) + (LEN_W+1)'(mask)
                         + (ext_lit ? (LEN_W+1)'(3) : (LEN_W+1)'(2));
               if (ext_lit) begin
                  lleft_in  = (ext_sum > {1'b0, LEN_SAT}) ? LEN_SAT : ext_sum[LEN_W-1:0];
                  lstate_in = 3'd4;
                  phase_in  = PH_LITS;
               end else begin
                  plen_in  = (ext_sum > {1'b0, LEN_SAT}) ? LEN_SAT : ext_sum[LEN_W-1:0];
                  phase_in = PH_FOLLOW1;
               end
            end
         end
         PH_M2: begin
            m_go   = 1'b1;
            m_dist = mdist_ff + {5'd0, in_byte, 3'd0};
            m_st   = lstate_ff[1:0];
         end
         PH_FOLLOW1: begin
            lowb_in  = in_byte;
            phase_in = PH_FOLLOW2;
         end
         PH_FOLLOW2: begin
            m_go   = 1'b1;
            m_dist = mdist_ff + {2'd0, follow[15:2]};
            m_st   = follow[1:0];
            m_m4   = (mdist_ff >= END_DIST);
         end
         PH_LITS: begin
            if (room != '0) begin
               q_cmd.lit  = 1'b1;
               q_cmd.data = in_byte;
               q_cmd.len  = LEN_W'(1);
               wc_in      = wc_ff + CNT_W'(1);
            end
            if (lleft_ff != '0) lleft_in = lleft_ff - LEN_W'(1);
            if (lleft_in == '0) phase_in = PH_INSTR;
         end
         PH_DONE: ;
         default: ;
      endcase

      if (instr) begin
         if (in_byte >= 8'd64) begin
            plen_in   = LEN_W'(in_byte[7:5]) + LEN_W'(1);
            mdist_in  = DIST_W'(in_byte[4:2]) + DIST_W'(1);
            lstate_in = {1'b0, in_byte[1:0]};
            phase_in  = PH_M2;
         end else if (in_byte >= 8'd32) begin
            low    = in_byte[4:0];
            base   = DIST_W'(1);
            low_go = 1'b1;
         end else if (in_byte >= 8'd16) begin
            low    = {2'd0, in_byte[2:0]};
            base   = END_DIST + {1'b0, in_byte[3], 14'd0};
            low_go = 1'b1;
         end else if (lstate_ff == '0) begin
            mdist_in = '0;
            if (in_byte != 8'd0) begin
               lleft_in  = LEN_W'(in_byte) + LEN_W'(3);
               lstate_in = 3'd4;
               phase_in  = PH_LITS;
            end else begin
               plen_in  = '0;
               phase_in = PH_EXT;
            end
         end else begin
            phase_in  = PH_DONE;
            lstate_in = ST_BAD_INSN;
         end
      end

      if (low_go) begin
         mdist_in = base;
         if (low != '0) begin
            plen_in  = LEN_W'(low) + LEN_W'(2);
            phase_in = PH_FOLLOW1;
         end else begin
            plen_in  = '0;
            phase_in = PH_EXT;
         end
      end

      if (m_go) begin
         if (m_m4 && m_dist == END_DIST) begin
            phase_in  = PH_DONE;
            lstate_in = ST_DONE;
         end else if (m_len > LEN_W'(MAX_MATCH)) begin
            phase_in  = PH_DONE;
            lstate_in = ST_LONG;
         end else if (CNT_W'(m_dist) > wc_ff) begin
            phase_in  = PH_DONE;
            lstate_in = ST_BAD_DIST;
         end else begin
            m_clamp        = (CNT_W'(m_len) < room) ? m_len : room[LEN_W-1:0];
            q_cmd.len      = m_clamp;
            q_cmd.distance = m_dist;
            wc_in          = wc_ff + CNT_W'(m_clamp);
            lstate_in      = {1'b0, m_st};
            if (m_st != 2'd0) begin
               lleft_in = LEN_W'(m_st);
               phase_in = PH_LITS;
            end else begin
               phase_in = PH_INSTR;
            end
         end
      end

      if (phase_ff != PH_DONE && in_last && phase_in != PH_DONE) begin
         phase_in  = PH_DONE;
         lstate_in = ST_DONE;
      end

      q_cmd.status = (phase_in == PH_DONE) ? lstate_in : ST_OK;
      q_cmd.total  = wc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         plen_ff   <= '0;
         mdist_ff  <= '0;
         lstate_ff <= '0;
         lleft_ff  <= '0;
         lowb_ff   <= '0;
         wc_ff     <= '0;
         cap_ff    <= CAP_RESET;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if (take) begin
            phase_ff  <= phase_in;
            plen_ff   <= plen_in;
            mdist_ff  <= mdist_in;
            lstate_ff <= lstate_in;
            lleft_ff  <= lleft_in;
            lowb_ff   <= lowb_in;
            wc_ff     <= wc_in;
         end
      end
   end

endmodule

// ===== design/lzo_cmdq.sv =====
// Short command queue between the parser and the copy engine.
// Depends on lzo_pkg.
`timescale 1ns / 1ps
module lzo_cmdq
   import lzo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, rp_ff;
   logic [PW:0]     cnt_ff;

   assign full  = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + PW'(1);
         if (pop)  rp_ff <= rp_ff + PW'(1);
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

endmodule

// ===== design/lzo_back.sv =====
// Copy engine: writes bytes into the history window, copies matches out of it
// by a read and a write per byte, and packs result words. Depends on lzo_pkg.
`timescale 1ns / 1ps
module lzo_back
   import lzo_pkg::*;
#(
   parameter int WINDOW_BYTES     = 65536,
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cmd_type           q_head,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [63:0]       out_data,
   output logic [3:0]        out_count,
   output logic              out_last,
   output logic [STAT_W-1:0] out_status,
   output logic [CNT_W-1:0]  out_total
);

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_WR   = 2'd2;

   logic [7:0]        mem [WINDOW_BYTES];
   logic [7:0]        rdata_ff;
   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [AW-1:0]     wp_next;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [CNT_W-1:0]  tot_ff, tot_in;
   logic [63:0]       pack_ff, pack_in;
   logic [3:0]        pcnt_ff, pcnt_in;
   logic              ov_ff, ov_in;
   logic [63:0]       od_ff, od_in;
   logic [3:0]        oc_ff, oc_in;
   logic              ol_ff, ol_in;
   logic [STAT_W-1:0] os_ff, os_in;
   logic [CNT_W-1:0]  ot_ff, ot_in;
   logic              out_free;
   logic              we, rd_en;
   logic [7:0]        wdata;
   logic [AW:0]       rd_diff;
   logic [AW-1:0]     rd_addr;
   logic [63:0]       merged;

   assign out_free   = !ov_ff || out_ready;
   assign out_valid  = ov_ff;
   assign out_data   = od_ff;
   assign out_count  = oc_ff;
   assign out_last   = ol_ff;
   assign out_status = os_ff;
   assign out_total  = ot_ff;

   // The write pointer wraps at the window size.
   assign wp_next = (wp_ff == AW'(WINDOW_BYTES - 1)) ? '0 : wp_ff + AW'(1);

   // The window wraps, so a distance that runs below zero comes back from the top.
   always_comb begin
      rd_diff = {1'b0, wp_ff} - (AW+1)'(dist_ff);
      if (rd_diff[AW]) rd_diff = rd_diff + (AW+1)'(WINDOW_BYTES);
      rd_addr = rd_diff[AW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      left_in  = left_ff;
      dist_in  = dist_ff;
      stat_in  = stat_ff;
      tot_in   = tot_ff;
      pack_in  = pack_ff;
      pcnt_in  = pcnt_ff;
      ov_in    = ov_ff && !out_ready;
      od_in    = od_ff;
      oc_in    = oc_ff;
      ol_in    = ol_ff;
      os_in    = os_ff;
      ot_in    = ot_ff;
      q_pop    = 1'b0;
      we       = 1'b0;
      rd_en    = 1'b0;
      wdata    = q_head.data;
      merged   = pack_ff | ({56'd0, rdata_ff} << {pcnt_ff, 3'd0});

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               if (q_head.len == '0 || q_head.lit) begin
                  ov_in = 1'b1;
                  od_in = q_head.lit ? {56'd0, q_head.data} : 64'd0;
                  oc_in = q_head.lit ? 4'd1 : 4'd0;
                  ol_in = 1'b1;
                  os_in = q_head.status;
                  ot_in = q_head.total;
                  if (q_head.lit) begin
                     we    = 1'b1;
                     wp_in = wp_next;
                  end
               end else begin
                  left_in  = q_head.len;
                  dist_in  = q_head.distance;
                  stat_in  = q_head.status;
                  tot_in   = q_head.total;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            if (out_free) begin
               we      = 1'b1;
               wdata   = rdata_ff;
               wp_in   = wp_next;
               left_in = left_ff - LEN_W'(1);
               pack_in = merged;
               pcnt_in = pcnt_ff + 4'd1;
               if (left_ff == LEN_W'(1) || pcnt_in == 4'(BYTES_PER_RESULT)) begin
                  ov_in   = 1'b1;
                  od_in   = merged;
                  oc_in   = pcnt_in;
                  ol_in   = (left_ff == LEN_W'(1));
                  os_in   = stat_ff;
                  ot_in   = tot_ff;
                  pack_in = '0;
                  pcnt_in = '0;
               end
               state_in = (left_ff == LEN_W'(1)) ? S_IDLE : S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wp_ff] <= wdata;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         pack_ff  <= '0;
         pcnt_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         pack_ff  <= pack_in;
         pcnt_ff  <= pcnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      dist_ff <= dist_in;
      stat_ff <= stat_in;
      tot_ff  <= tot_in;
      od_ff   <= od_in;
      oc_ff   <= oc_in;
      ol_ff   <= ol_in;
      os_ff   <= os_in;
      ot_ff   <= ot_in;
   end

endmodule

// ===== design/lzo1x_stream_decompressor_top.sv =====
// LZO1X stream decompressor: takes compressed bytes on req_, returns packed
// decompressed bytes on rsp_, out_capacity is written over csr_.
// A parser accepts one compressed byte per cycle, unless the queue is full,
// into a four-entry command queue; a copy engine drains the queue into the
// 64 KiB history window. Every accepted byte produces one result or more;
// the final result of a byte has rsp_tlast set, and a byte that yields no
// output gives one empty result. A literal byte is written into the window
// as the copy engine takes its command; a match byte takes a registered read
// of the window memory followed by its write, and the write waits while the
// result register holds a word that is not taken.
// req_tready drops only while the command queue is full, so the parser runs
// ahead of the copy engine by up to four bytes.
// When rsp_tready is low the result register holds and the copy engine
// waits; the queue then fills and stalls the input.
// Reset clears the parser, the queue and the output register; the window
// needs no clearing, since a match never reaches past the bytes written.
// An error or end of stream latches until the next reset.
`timescale 1ns / 1ps
module lzo1x_stream_decompressor_top
   import lzo_pkg::*;
#(
   parameter int WINDOW_BYTES     = 65536,
   parameter int MAX_MATCH        = 512,
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // in_byte
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [95:0]      rsp_tdata,   // out_data, out_count, total_bytes, zero pad
   output logic             rsp_tlast,
   output logic [2:0]       rsp_tuser    // status
);

   logic        q_full, q_push, q_pop, q_empty;
   cmd_type     q_cmd, q_head;
   logic [63:0] out_data;
   logic [3:0]  out_count;
   logic [CNT_W-1:0] out_total;

   lzo_front #(.MAX_MATCH(MAX_MATCH)) u_front (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .in_valid(req_tvalid), .in_byte(req_tdata), .in_last(req_tlast),
      .in_ready(req_tready), .q_full, .q_push, .q_cmd
   );

   lzo_cmdq u_cmdq (
      .clock, .reset, .push(q_push), .push_cmd(q_cmd), .full(q_full),
      .pop(q_pop), .empty(q_empty), .head(q_head)
   );

   lzo_back #(.WINDOW_BYTES(WINDOW_BYTES), .BYTES_PER_RESULT(BYTES_PER_RESULT)) u_back (
      .clock, .reset, .q_empty, .q_head, .q_pop,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data, .out_count,
      .out_last(rsp_tlast), .out_status(rsp_tuser), .out_total
   );

   assign rsp_tdata = {3'd0, out_total, out_count, out_data};

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("command queue underflow");

   a_partial_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_count != 4'(BYTES_PER_RESULT) |-> rsp_tlast)
      else $error("partial result word not marked last");

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_BAD_INSN || rsp_tuser == ST_BAD_DIST
                     || rsp_tuser == ST_LONG) |-> out_count == 4'd0)
      else $error("error result carries data");

endmodule
